>>> design/sts_pkg.sv
`default_nettype none
package sts_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 64;
    localparam int DATA_W              = 32;
    localparam int POS_W               = 6;
    localparam int STATUS_W            = 2;

    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [POS_W-1:0]    pos_t;
    typedef logic signed [DATA_W-1:0] data_t;

    localparam status_t ST_APPENDED  = 2'd0;
    localparam status_t ST_FULL      = 2'd1;
    localparam status_t ST_FOUND     = 2'd2;
    localparam status_t ST_NOT_FOUND = 2'd3;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

endpackage
`default_nettype wire

>>> design/sorted_table_binary_search.sv
`default_nettype none
// Channel  Handshake            Fields                 Dir  Carries
// request  in_valid/in_ready    operation, value, key  in   append value or search key
// result   out_valid/out_ready  status, position       out  status and entry index
//
// An append is answered from the idle state without a table read. A search makes
// P probes, at most floor(log2(fill count)) + 1; each probe is one read of the
// table RAM (registered) followed by the compare. Reset clears state, fill count
// and out_valid; table contents stay undefined until written.
// A result that is not taken holds the block: no request is taken until the
// output register is free.
module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = sts_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             operation,
    input  wire sts_pkg::data_t   value,
    input  wire sts_pkg::data_t   key,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output sts_pkg::status_t      status,
    output sts_pkg::pos_t         position
);
    import sts_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] start_reg, start_next;
    logic [CW-1:0] size_reg, size_next;
    data_t         key_reg, key_next;
    logic          out_valid_reg, out_valid_next;
    status_t       status_reg, status_next;
    pos_t          position_reg, position_next;

    logic [CW-1:0] mid;
    logic [CW-1:0] idx;
    logic [CW-1:0] size_less;
    logic          out_free;
    logic          accept;
    logic          full;
    logic          mem_we;
    logic          mem_re;
    data_t         entry;

    assign mid       = size_reg >> 1;
    assign idx       = start_reg + mid;
    assign size_less = size_reg - mid - CW'(1);
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && out_free;
    assign accept    = in_valid && in_ready;
    assign full      = (fill_reg == CW'(TABLE_DEPTH));
    assign mem_we    = accept && (operation == OP_APPEND) && !full;
    assign mem_re    = (state_reg == S_READ);

    sts_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (fill_reg[AW-1:0]),
        .wdata (value),
        .re    (mem_re),
        .raddr (idx[AW-1:0]),
        .rdata (entry)
    );

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        start_next     = start_reg;
        size_next      = size_reg;
        key_next       = key_reg;
        status_next    = status_reg;
        position_next  = position_reg;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (operation == OP_APPEND)
                    begin
                        out_valid_next = 1'b1;
                        if (full)
                        begin
                            status_next   = ST_FULL;
                            position_next = '0;
                        end
                        else
                        begin
                            status_next   = ST_APPENDED;
                            position_next = POS_W'(fill_reg);
                            fill_next     = fill_reg + CW'(1);
                        end
                    end
                    else if (fill_reg == '0)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = ST_NOT_FOUND;
                        position_next  = '0;
                    end
                    else
                    begin
                        key_next   = key;
                        start_next = '0;
                        size_next  = fill_reg;
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                // hold the span and the read data until the output is free
                if (entry == key_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = ST_FOUND;
                        position_next  = POS_W'(idx);
                        state_next     = S_IDLE;
                    end
                end
                else if (entry < key_reg)
                begin
                    if (size_less == '0)
                    begin
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            status_next    = ST_NOT_FOUND;
                            position_next  = '0;
                            state_next     = S_IDLE;
                        end
                    end
                    else
                    begin
                        start_next = idx + CW'(1);
                        size_next  = size_less;
                        state_next = S_READ;
                    end
                end
                else
                begin
                    if (mid == '0)
                    begin
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            status_next    = ST_NOT_FOUND;
                            position_next  = '0;
                            state_next     = S_IDLE;
                        end
                    end
                    else
                    begin
                        size_next  = mid;
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg    <= start_next;
        size_reg     <= size_next;
        key_reg      <= key_next;
        status_reg   <= status_next;
        position_reg <= position_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign position  = position_reg;

endmodule
`default_nettype wire

>>> design/sts_ram.sv
`default_nettype none
module sts_ram #(
    parameter int DEPTH = sts_pkg::DEFAULT_TABLE_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [AW-1:0]        waddr,
    input  wire sts_pkg::data_t       wdata,
    input  wire logic                 re,
    input  wire logic [AW-1:0]        raddr,
    output sts_pkg::data_t            rdata
);
    import sts_pkg::*;

    data_t mem [DEPTH];
    data_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> design/sts_checker.sv
`default_nettype none
module sts_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_valid,
    input wire logic             in_ready,
    input wire logic             out_valid,
    input wire logic             out_ready,
    input wire sts_pkg::status_t status,
    input wire sts_pkg::pos_t    position
);
    import sts_pkg::*;

    logic [1:0] pending_reg, pending_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg + 2'(in_acc) - 2'(out_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(position))
        else $error("result changed while stalled");

    a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL || status == ST_NOT_FOUND) |-> position == '0)
        else $error("nonzero position on full or not found");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 2'd0)
        else $error("result without a request");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> pending_reg == 2'd0 || out_acc)
        else $error("request taken while another is open");

endmodule

bind sorted_table_binary_search sts_checker u_sts_checker (.*);
`default_nettype wire

>>> sim/tb_sorted_table_binary_search.sv
module tb_sorted_table_binary_search;
    import sts_pkg::*;

    localparam int    TABLE_DEPTH  = DEFAULT_TABLE_DEPTH;
    localparam int    RANDOM_ITEMS = 400;
    localparam int    IDLE_LIMIT   = 2000;
    localparam int    DRAIN_CYCLES = 40;
    localparam data_t DATA_MIN     = 32'sh8000_0000;
    localparam data_t DATA_MAX     = 32'sh7FFF_FFFF;

    typedef struct {
        logic  op;
        data_t value;
        data_t key;
    } request_t;

    typedef struct {
        status_t status;
        pos_t    position;
    } response_t;

    logic    clk;
    logic    rst_n     = 1'b0;
    logic    in_valid  = 1'b0;
    logic    operation = OP_APPEND;
    data_t   value     = '0;
    data_t   key       = '0;
    logic    out_ready = 1'b0;
    logic    in_ready;
    logic    out_valid;
    status_t status;
    pos_t    position;

    sorted_table_binary_search #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .value     (value),
        .key       (key),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .position  (position)
    );

    request_t    request_queue [$];
    response_t   expected_responses [$];
    data_t       stim_table [$];

    // Table image used for prediction, updated on accepted requests only.
    data_t       model_table [TABLE_DEPTH];
    int unsigned model_fill = 0;

    int          total_requests    = 0;
    int          accepted_requests = 0;
    int          fail_count        = 0;
    int          idle_cycles       = 0;
    int          status_seen [4]   = '{0, 0, 0, 0};
    bit          req_accepted      = 1'b0;
    int          burst_left        = 1;
    int          gap_left          = 0;
    int          rx_cycle          = 0;
    int          stall_left        = 0;
    bit          ready_next;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void lookup_response(input logic op, input data_t val, input data_t srch,
                                            output status_t st, output pos_t pos);
        int unsigned lo;
        int unsigned span;
        int unsigned half;
        int unsigned probe;
        bit          done;
        st   = ST_NOT_FOUND;
        pos  = '0;
        done = 1'b0;
        if (op == OP_APPEND)
        begin
            if (model_fill >= TABLE_DEPTH)
            begin
                st = ST_FULL;
            end
            else
            begin
                model_table[model_fill] = val;
                pos        = pos_t'(model_fill);
                model_fill = model_fill + 1;
                st         = ST_APPENDED;
            end
        end
        else
        begin
            lo   = 0;
            span = model_fill;
            while (span > 0 && !done)
            begin
                half  = span / 2;
                probe = lo + half;
                if (model_table[probe] == srch)
                begin
                    st   = ST_FOUND;
                    pos  = pos_t'(probe);
                    done = 1'b1;
                end
                else if ($signed(model_table[probe]) < $signed(srch))
                begin
                    lo   = probe + 1;
                    span = span - half - 1;
                end
                else
                begin
                    span = half;
                end
            end
        end
    endfunction

    task automatic add_request(input logic op, input data_t val, input data_t srch);
        request_t r;
        r.op    = op;
        r.value = val;
        r.key   = srch;
        request_queue.push_back(r);
        total_requests++;
        if (op == OP_APPEND && stim_table.size() < TABLE_DEPTH)
            stim_table.push_back(val);
    endtask

    // Request driver: bursts of random length separated by random gaps.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (in_valid && !req_accepted)
        begin
            // hold the request until it is taken
        end
        else if (gap_left > 0)
        begin
            in_valid <= 1'b0;
            gap_left--;
        end
        else if (request_queue.size() > 0)
        begin
            in_valid  <= 1'b1;
            operation <= request_queue[0].op;
            value     <= request_queue[0].value;
            key       <= request_queue[0].key;
            void'(request_queue.pop_front());
            if (burst_left <= 1)
            begin
                burst_left = $urandom_range(1, 24);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
            else
            begin
                burst_left--;
            end
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    // Result receiver: rotate through steady, random, long-stall and sparse phases.
    always @(negedge clk)
    begin
        rx_cycle++;
        case ((rx_cycle / 80) % 4)
            0: ready_next = 1'b1;
            1: ready_next = 1'($urandom_range(0, 1));
            2:
            begin
                if (stall_left > 0)
                begin
                    ready_next = 1'b0;
                    stall_left--;
                end
                else
                begin
                    ready_next = 1'b1;
                    if ($urandom_range(0, 3) == 0)
                        stall_left = $urandom_range(1, 20);
                end
            end
            default: ready_next = ($urandom_range(0, 3) == 0);
        endcase
        out_ready <= ready_next;
    end

    // Monitor: predict on accepted requests, check accepted results, watch for a hang.
    always @(posedge clk)
    begin
        response_t want;
        status_t   exp_st;
        pos_t      exp_pos;
        bit        out_fire;
        req_accepted = in_valid && in_ready;
        out_fire     = out_valid && out_ready;
        if (rst_n)
        begin
            if (req_accepted)
            begin
                lookup_response(operation, value, key, exp_st, exp_pos);
                want.status   = exp_st;
                want.position = exp_pos;
                expected_responses.push_back(want);
                accepted_requests++;
            end
            if (out_fire)
            begin
                if (expected_responses.size() == 0)
                begin
                    $error("unexpected result: status %0d position %0d", status, position);
                    fail_count++;
                end
                else
                begin
                    want = expected_responses.pop_front();
                    status_seen[status]++;
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        fail_count++;
                    end
                    if (position !== want.position)
                    begin
                        $error("position: expected %0d, got %0d", want.position, position);
                        fail_count++;
                    end
                end
            end
            if (req_accepted || out_fire)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles, %0d results outstanding",
                         IDLE_LIMIT, expected_responses.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        longint ramp;
        int     odd_slot;
        int     pick;
        int     idx;
        data_t  srch;

        // Empty table, then a short table with a repeated entry.
        add_request(OP_SEARCH, DATA_MAX, 32'sd0);
        add_request(OP_SEARCH, DATA_MIN, DATA_MIN);
        add_request(OP_SEARCH, 32'sd0, DATA_MAX);
        add_request(OP_APPEND, DATA_MIN, 32'shFFFF_FFFF);
        add_request(OP_SEARCH, 32'shFFFF_FFFF, DATA_MIN);
        add_request(OP_SEARCH, 32'sd0, DATA_MAX);
        add_request(OP_SEARCH, 32'sd0, DATA_MIN + 1);
        add_request(OP_APPEND, DATA_MIN + 1, 32'sd0);
        add_request(OP_APPEND, DATA_MIN + 1, DATA_MAX);
        add_request(OP_SEARCH, 32'sd0, DATA_MIN + 1);
        add_request(OP_SEARCH, DATA_MAX, DATA_MIN);
        add_request(OP_SEARCH, 32'sd0, -32'sd1);
        add_request(OP_APPEND, -32'sd5, DATA_MIN);
        add_request(OP_SEARCH, 32'sd0, -32'sd5);
        add_request(OP_SEARCH, 32'sd0, -32'sd6);
        add_request(OP_SEARCH, 32'sd0, 32'sd0);

        // Ascending fill with repeats and one out-of-order entry; top slot gets the maximum.
        ramp     = -5;
        odd_slot = $urandom_range(20, 55);
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if ((stim_table.size() < TABLE_DEPTH && $urandom_range(0, 2) == 0) ||
                (stim_table.size() >= TABLE_DEPTH && $urandom_range(0, 9) == 0))
            begin
                if (stim_table.size() >= TABLE_DEPTH)
                begin
                    add_request(OP_APPEND, $urandom, $urandom);
                end
                else if (stim_table.size() == TABLE_DEPTH - 1)
                begin
                    add_request(OP_APPEND, DATA_MAX, $urandom);
                end
                else if (stim_table.size() == odd_slot)
                begin
                    add_request(OP_APPEND, $urandom, $urandom);
                end
                else
                begin
                    if ($urandom_range(0, 7) != 0)
                        ramp = ramp + $urandom_range(1, 32'h0800_0000);
                    if (ramp > 64'sh7FFF_FFFF)
                        ramp = 64'sh7FFF_FFFF;
                    add_request(OP_APPEND, data_t'(ramp), $urandom);
                end
            end
            else
            begin
                pick = $urandom_range(0, 9);
                srch = $urandom;
                if (stim_table.size() > 0 && pick <= 6)
                begin
                    idx  = $urandom_range(0, stim_table.size() - 1);
                    srch = stim_table[idx];
                    if (pick == 5)
                        srch = srch + 1;
                    else if (pick == 6)
                        srch = srch - 1;
                end
                else if (pick == 8)
                begin
                    srch = DATA_MIN;
                end
                else if (pick == 9)
                begin
                    srch = DATA_MAX;
                end
                add_request(OP_SEARCH, $urandom, srch);
            end
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (accepted_requests < total_requests || expected_responses.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("%0d requests: %0d appended, %0d dropped on full table",
                 total_requests, status_seen[ST_APPENDED], status_seen[ST_FULL]);
        $display("searches: %0d found, %0d not found; %0d mismatches",
                 status_seen[ST_FOUND], status_seen[ST_NOT_FOUND], fail_count);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> filelist.f
design/sts_pkg.sv
design/sts_ram.sv
design/sorted_table_binary_search.sv
design/sts_checker.sv
sim/tb_sorted_table_binary_search.sv
